@@ rtl/bld_pkg.sv @@
package bld_pkg;

  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned FACTOR_W   = 16;
  localparam int unsigned WCOUNT_W   = 6;
  localparam int unsigned FRAC_W     = 14;

  localparam logic [FACTOR_W-1:0] ENABLE_RST  = 16'd15565;
  localparam logic [FACTOR_W-1:0] DISABLE_RST = 16'd17039;
  localparam logic [WCOUNT_W-1:0] WINDOW_RST  = 6'd10;

  localparam logic signed [SPEED_W:0] HALF_OFFSET = 17'sd128;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = 3;
  localparam int unsigned QCNT_W = 4;
  localparam int unsigned PEND_W = 3;

  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_DISABLE = 2'd1,
    REG_WINDOW  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] enable_factor;
    logic [FACTOR_W-1:0] disable_factor;
    logic [WCOUNT_W-1:0] window_count;
  } cfg_t;

  typedef struct packed {
    logic on;
    logic off;
  } verdict_t;

  typedef struct packed {
    logic light;
    logic last;
  } entry_t;

endpackage

@@ rtl/bld_regs.sv @@
module bld_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bld_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bld_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bld_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output bld_pkg::cfg_t                    cfg
);
  import bld_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  reg_index_t idx;

  assign idx    = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_ENABLE:  cfg_nxt.enable_factor  = pwdata[FACTOR_W-1:0];
        REG_DISABLE: cfg_nxt.disable_factor = pwdata[FACTOR_W-1:0];
        REG_WINDOW:  cfg_nxt.window_count   = pwdata[WCOUNT_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:  prdata = CFG_DATA_W'(cfg_r.enable_factor);
      REG_DISABLE: prdata = CFG_DATA_W'(cfg_r.disable_factor);
      REG_WINDOW:  prdata = CFG_DATA_W'(cfg_r.window_count);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_factor  <= ENABLE_RST;
      cfg_r.disable_factor <= DISABLE_RST;
      cfg_r.window_count   <= WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/bld_ring.sv @@
module bld_ring #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_accept,
  input  logic signed [bld_pkg::SPEED_W-1:0]                in_speed,
  input  logic [bld_pkg::WCOUNT_W-1:0]                      window_count,
  output logic                                              mid_valid,
  output logic signed [bld_pkg::SPEED_W-1:0]                mid_speed,
  output logic [bld_pkg::MAG_W-1:0]                         mid_mag,
  output logic [$clog2(WINDOW_MAX+1)-1:0]                   mid_fill,
  output logic [bld_pkg::MAG_W+$clog2(WINDOW_MAX+1)-1:0]    mid_sum
);
  import bld_pkg::*;

  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW   = $clog2(WINDOW_MAX + 1);
  localparam int SW   = MAG_W + FW;
  localparam int WC_W = (FW > WCOUNT_W) ? FW : WCOUNT_W;

  logic [MAG_W-1:0] mem [WINDOW_MAX];
  logic [MAG_W-1:0] rd_r;

  logic [AW-1:0]    wp_r, wp_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;

  logic                       s1_valid_r;
  logic signed [SPEED_W-1:0]  s1_speed_r;
  logic [MAG_W-1:0]           s1_mag_r;
  logic [FW-1:0]              s1_fill_r;
  logic                       s1_drop_r;

  logic                       s2_valid_r;
  logic signed [SPEED_W-1:0]  s2_speed_r;
  logic [MAG_W-1:0]           s2_mag_r;
  logic [FW-1:0]              s2_fill_r;
  logic [SW-1:0]              sum_r, sum_nxt;

  logic [SPEED_W-1:0] abs_val;
  logic [MAG_W-1:0]   mag;
  logic [WC_W-1:0]    wc_ext;
  logic [FW-1:0]      win;
  logic [FW:0]        fill_inc;
  logic               drop;
  logic [FW:0]        back_raw;
  logic [FW:0]        back_idx;
  logic [AW-1:0]      rd_addr;

  assign abs_val = in_speed[SPEED_W-1] ? (~in_speed + 1'b1) : in_speed;
  assign mag     = abs_val[SPEED_W-1] ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];
  assign wc_ext  = WC_W'(window_count);

  always_comb begin
    if (wc_ext == '0) begin
      win = FW'(1);
    end else if (wc_ext > WC_W'(WINDOW_MAX)) begin
      win = FW'(WINDOW_MAX);
    end else begin
      win = wc_ext[FW-1:0];
    end
  end

  assign fill_inc = {1'b0, fill_r} + 1'b1;
  assign drop     = fill_inc > {1'b0, win};
  assign fill_nxt = drop ? fill_r : fill_inc[FW-1:0];

  assign back_raw = (FW+1)'(wp_r) + (FW+1)'(WINDOW_MAX) - {1'b0, fill_r};
  assign back_idx = (back_raw >= (FW+1)'(WINDOW_MAX)) ?
                    back_raw - (FW+1)'(WINDOW_MAX) : back_raw;
  assign rd_addr  = back_idx[AW-1:0];

  assign wp_nxt = (wp_r == AW'(WINDOW_MAX - 1)) ? '0 : wp_r + 1'b1;

  assign sum_nxt = sum_r + SW'(s1_mag_r) - (s1_drop_r ? SW'(rd_r) : '0);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_r        <= mem[rd_addr];
      mem[wp_r]   <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      s1_valid_r <= in_accept;
      s2_valid_r <= s1_valid_r;
      if (in_accept) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
      if (s1_valid_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_speed_r <= in_speed;
      s1_mag_r   <= mag;
      s1_fill_r  <= fill_nxt;
      s1_drop_r  <= drop;
    end
    if (s1_valid_r) begin
      s2_speed_r <= s1_speed_r;
      s2_mag_r   <= s1_mag_r;
      s2_fill_r  <= s1_fill_r;
    end
  end

  assign mid_valid = s2_valid_r;
  assign mid_speed = s2_speed_r;
  assign mid_mag   = s2_mag_r;
  assign mid_fill  = s2_fill_r;
  assign mid_sum   = sum_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_MAX))
    else $error("Fill level exceeds the ring depth.");
`endif

endmodule

@@ rtl/bld_judge.sv @@
module bld_judge #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              mid_valid,
  input  logic signed [bld_pkg::SPEED_W-1:0]                mid_speed,
  input  logic [bld_pkg::MAG_W-1:0]                         mid_mag,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]                   mid_fill,
  input  logic [bld_pkg::MAG_W+$clog2(WINDOW_MAX+1)-1:0]    mid_sum,
  input  logic [bld_pkg::FACTOR_W-1:0]                      enable_factor,
  input  logic [bld_pkg::FACTOR_W-1:0]                      disable_factor,
  output logic                                              done,
  output bld_pkg::verdict_t                                 verdict
);
  import bld_pkg::*;

  localparam int FW   = $clog2(WINDOW_MAX + 1);
  localparam int SW   = MAG_W + FW;
  localparam int MN_W = MAG_W + FW;
  localparam int SG_W = SPEED_W + 1 + FW + 1;
  localparam int EN_W = SW + FACTOR_W;
  localparam int CW   = SW + FACTOR_W + 2;

  logic signed [SPEED_W:0]  shifted;
  logic signed [FW:0]       n_signed;
  logic [MN_W-1:0]          mn;
  logic signed [SG_W-1:0]   sg;
  logic [EN_W-1:0]          en;
  logic [EN_W-1:0]          dis;

  logic                     v3_r;
  logic [MN_W-1:0]          mn_r;
  logic signed [SG_W-1:0]   sg_r;
  logic [EN_W-1:0]          en_r;
  logic [EN_W-1:0]          dis_r;
  logic                     brake_r, brake_nxt;

  logic signed [CW-1:0]     lhs_c, sg_c, en_c, dis_c;
  logic                     turn_on, turn_off, lit;

  assign shifted  = {mid_speed[SPEED_W-1], mid_speed} + HALF_OFFSET;
  assign n_signed = $signed({1'b0, mid_fill});
  assign mn       = MN_W'(mid_mag) * MN_W'(mid_fill);
  assign sg       = SG_W'(shifted) * SG_W'(n_signed);
  assign en       = EN_W'(mid_sum) * EN_W'(enable_factor);
  assign dis      = EN_W'(mid_sum) * EN_W'(disable_factor);

  always_ff @(posedge clk) begin
    if (mid_valid) begin
      mn_r  <= mn;
      sg_r  <= sg;
      en_r  <= en;
      dis_r <= dis;
    end
  end

  assign lhs_c = $signed({{(CW-MN_W-FRAC_W){1'b0}}, mn_r, {FRAC_W{1'b0}}});
  assign sg_c  = $signed({{(CW-SG_W-FRAC_W){sg_r[SG_W-1]}}, sg_r, {FRAC_W{1'b0}}});
  assign en_c  = $signed({{(CW-EN_W){1'b0}}, en_r});
  assign dis_c = $signed({{(CW-EN_W){1'b0}}, dis_r});

  assign turn_on   = !brake_r && (lhs_c < en_c) && (sg_c < en_c);
  assign lit       = brake_r || turn_on;
  assign turn_off  = lit && (lhs_c > dis_c);
  assign brake_nxt = v3_r ? (lit && !turn_off) : brake_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      brake_r <= 1'b0;
    end else begin
      v3_r    <= mid_valid;
      brake_r <= brake_nxt;
    end
  end

  assign done        = v3_r;
  assign verdict.on  = turn_on;
  assign verdict.off = turn_off;

endmodule

@@ rtl/bld_outq.sv @@
module bld_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  logic               done,
  input  bld_pkg::verdict_t  verdict,
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output logic               out_brake_light,
  output logic               out_last
);
  import bld_pkg::*;

  entry_t            q_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [PEND_W-1:0] pend_left;
  logic [QCNT_W:0]   room_need;
  logic [1:0]        npush;
  logic              pop;
  entry_t            first_e, second_e;
  logic [QPTR_W-1:0] wptr_next1;

  always_comb begin
    first_e  = '{light: 1'b0, last: 1'b1};
    second_e = '{light: 1'b0, last: 1'b1};
    npush    = 2'd0;
    if (done) begin
      if (verdict.on && verdict.off) begin
        first_e = '{light: 1'b1, last: 1'b0};
        npush   = 2'd2;
      end else if (verdict.on) begin
        first_e = '{light: 1'b1, last: 1'b1};
        npush   = 2'd1;
      end else if (verdict.off) begin
        npush   = 2'd1;
      end
    end
  end

  assign wptr_next1 = wptr_r + 1'b1;
  assign pop        = out_valid && !out_stall;
  assign count_nxt  = count_r + QCNT_W'(npush) - QCNT_W'(pop);
  assign pend_nxt   = pend_r + PEND_W'(in_accept) - PEND_W'(done);
  assign pend_left  = pend_r - PEND_W'(done);
  assign room_need  = (QCNT_W+1)'(count_r) + (QCNT_W+1)'(npush) +
                      (QCNT_W+1)'({pend_left, 1'b0}) + (QCNT_W+1)'(2);
  assign in_stall   = room_need > (QCNT_W+1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      q_r[wptr_r] <= first_e;
    end
    if (npush == 2'd2) begin
      q_r[wptr_next1] <= second_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
      pend_r  <= '0;
    end else begin
      wptr_r  <= wptr_r + QPTR_W'(npush);
      rptr_r  <= rptr_r + QPTR_W'(pop);
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign out_valid       = count_r != '0;
  assign out_brake_light = q_r[rptr_r].light;
  assign out_last        = q_r[rptr_r].last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("Result queue holds more entries than its depth.");

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> pend_r != '0)
    else $error("A sample completed that was never taken in.");

  a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> pend_r != '0)
    else $error("An accepted sample is not tracked as in flight.");
`endif

endmodule

@@ rtl/brake_light_decel_detector_core.sv @@
// Channel   Direction  Ports                                   Transfer when
// input     in         in_valid, in_stall, in_speed            in_valid && !in_stall
// result    out        out_valid, out_stall, out_brake_light,  out_valid && !out_stall
//                      out_last
// config    in         psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//                      prdata, pready
//
// One sample is taken per cycle while in_stall is low. Its results leave the result
// queue at the earliest after the ring memory read, multiply stage and queue write.
// A sample that changes the light both ways gives two results, which the queue offers
// one per cycle while out_stall stays low.
// Reset is synchronous; the magnitude ring is not cleared and needs no clearing pass.
// in_stall rises only when the eight-entry result queue could overflow, under out_stall
// or a run of samples that each give two results.
module brake_light_decel_detector_core #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [bld_pkg::SPEED_W-1:0]       in_speed,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     out_brake_light,
  output logic                                     out_last,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [bld_pkg::CFG_ADDR_W-1:0]           paddr,
  input  logic [bld_pkg::CFG_DATA_W-1:0]           pwdata,
  output logic [bld_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                     pready
);
  import bld_pkg::*;

  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int SW = MAG_W + FW;

  cfg_t                       cfg;
  logic                       in_accept;
  logic                       mid_valid;
  logic signed [SPEED_W-1:0]  mid_speed;
  logic [MAG_W-1:0]           mid_mag;
  logic [FW-1:0]              mid_fill;
  logic [SW-1:0]              mid_sum;
  logic                       done;
  verdict_t                   verdict;

  assign in_accept = in_valid && !in_stall;

  bld_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bld_ring #(.WINDOW_MAX(WINDOW_MAX)) u_ring (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_speed     (in_speed),
    .window_count (cfg.window_count),
    .mid_valid    (mid_valid),
    .mid_speed    (mid_speed),
    .mid_mag      (mid_mag),
    .mid_fill     (mid_fill),
    .mid_sum      (mid_sum)
  );

  bld_judge #(.WINDOW_MAX(WINDOW_MAX)) u_judge (
    .clk            (clk),
    .rst_n          (rst_n),
    .mid_valid      (mid_valid),
    .mid_speed      (mid_speed),
    .mid_mag        (mid_mag),
    .mid_fill       (mid_fill),
    .mid_sum        (mid_sum),
    .enable_factor  (cfg.enable_factor),
    .disable_factor (cfg.disable_factor),
    .done           (done),
    .verdict        (verdict)
  );

  bld_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .done            (done),
    .verdict         (verdict),
    .out_stall       (out_stall),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_brake_light (out_brake_light),
    .out_last        (out_last)
  );

endmodule
